[rtl/sars_pkg.sv]
// Shared types, codes and widths for the summed-area range-sum block.
package sars_pkg;

    localparam int MODE_W    = 2;
    localparam int CELL_W    = 16;
    localparam int COORD_W   = 7;
    localparam int SUM_W     = 28;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL       = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INCOMPLETE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_RECT   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

    // The four corner terms of a rectangle query, in read order.
    localparam logic [1:0] TERM_BR = 2'd0;  // (bottom, right), added
    localparam logic [1:0] TERM_BL = 2'd1;  // (bottom, left - 1), subtracted
    localparam logic [1:0] TERM_TR = 2'd2;  // (top - 1, right), subtracted
    localparam logic [1:0] TERM_TL = 2'd3;  // (top - 1, left - 1), added

    typedef struct packed {
        logic        [MODE_W-1:0]  mode;
        logic signed [CELL_W-1:0]  cell_value;
        logic        [COORD_W-1:0] top_row;
        logic        [COORD_W-1:0] left_col;
        logic        [COORD_W-1:0] bottom_row;
        logic        [COORD_W-1:0] right_col;
    } t_req;

    typedef struct packed {
        logic signed [SUM_W-1:0]  range_sum;
        logic        [STAT_W-1:0] status;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LD_RD,
        ST_LD_WR,
        ST_Q0,
        ST_Q1,
        ST_Q2,
        ST_Q3,
        ST_Q4,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       capture;
        logic       decode;
        logic       load_read;
        logic       load_commit;
        logic       rd_en;
        logic [1:0] term;
        logic       accum;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic load_go;
        logic query_go;
        logic out_busy;
    } t_dp_stat;

endpackage

[rtl/sars_ctrl.sv]
// Sequencing state machine for the summed-area range-sum block.
module sars_ctrl
    import sars_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_stat.load_go) begin
                    n_state = ST_LD_RD;
                end else if (i_stat.query_go) begin
                    n_state = ST_Q0;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_LD_RD: begin
                o_cmd.load_read = 1'b1;
                n_state         = ST_LD_WR;
            end
            ST_LD_WR: begin
                o_cmd.load_commit = 1'b1;
                n_state           = ST_DONE;
            end
            ST_Q0: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.term  = TERM_BR;
                n_state     = ST_Q1;
            end
            ST_Q1: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.term  = TERM_BL;
                o_cmd.accum = 1'b1;
                n_state     = ST_Q2;
            end
            ST_Q2: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.term  = TERM_TR;
                o_cmd.accum = 1'b1;
                n_state     = ST_Q3;
            end
            ST_Q3: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.term  = TERM_TL;
                o_cmd.accum = 1'b1;
                n_state     = ST_Q4;
            end
            ST_Q4: begin
                o_cmd.accum = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/sars_datapath.sv]
// Table memory, load counters, accumulator and result register of the range-sum block.
module sars_datapath
    import sars_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_req                 i_in_data,
    input  logic                 i_cfg_wr,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_rsp                 o_out_data
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CW     = (DIM_W > COORD_W) ? DIM_W : COORD_W;
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SUM_W-1:0] mem [DEPTH];
    logic [SUM_W-1:0] r_rdata;

    logic [CFG_W-1:0]  r_rows_cfg;
    logic [CFG_W-1:0]  r_cols_cfg;
    logic [DIM_W-1:0]  r_row;
    logic [DIM_W-1:0]  r_col;
    logic [SUM_W-1:0]  r_run;
    logic              r_complete;
    logic              r_out_valid;

    t_req              r_req;
    logic [SUM_W-1:0]  r_acc;
    logic [STAT_W-1:0] r_code;
    logic [1:0]        r_term;
    logic              r_rd_zero;
    t_rsp              r_out;

    logic [CW-1:0]     rows_eff;
    logic [CW-1:0]     cols_eff;
    logic [CW-1:0]     row_ext;
    logic [CW-1:0]     col_ext;
    logic [CW-1:0]     t_ext;
    logic [CW-1:0]     l_ext;
    logic [CW-1:0]     b_ext;
    logic [CW-1:0]     r_ext;
    logic              load_full;
    logic              rect_bad;
    logic [STAT_W-1:0] code_c;
    logic [SUM_W-1:0]  cell_ext;
    logic [SUM_W-1:0]  run_nx;
    logic [SUM_W-1:0]  load_sum;
    logic [SUM_W-1:0]  rd_term_val;
    logic [DIM_W-1:0]  col_nx;
    logic [DIM_W-1:0]  row_nx;
    logic [CW-1:0]     q_row;
    logic [CW-1:0]     q_col;
    logic              q_zero;
    logic [CW-1:0]     ld_row;
    logic [ADDR_W-1:0] addr;
    logic              mem_re;
    logic              rd_zero_c;

    function automatic logic [CW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CW-1:0] ve;
        ve = CW'(v);
        if (ve == '0) begin
            return CW'(1);
        end else if (ve > CW'(MAX_DIM)) begin
            return CW'(MAX_DIM);
        end
        return ve;
    endfunction

    function automatic logic [ADDR_W-1:0] tab_addr(input logic [CW-1:0] row,
                                                   input logic [CW-1:0] col);
        logic [IDX_W-1:0] ri;
        logic [IDX_W-1:0] ci;
        ri = row[IDX_W-1:0];
        ci = col[IDX_W-1:0];
        return ADDR_W'(ri) * ADDR_W'(MAX_DIM) + ADDR_W'(ci);
    endfunction

    // Decode of the captured request against the loading state.
    always_comb begin
        rows_eff  = clamp_dim(r_rows_cfg);
        cols_eff  = clamp_dim(r_cols_cfg);
        row_ext   = CW'(r_row);
        col_ext   = CW'(r_col);
        t_ext     = CW'(r_req.top_row);
        l_ext     = CW'(r_req.left_col);
        b_ext     = CW'(r_req.bottom_row);
        r_ext     = CW'(r_req.right_col);
        load_full = r_complete || (row_ext >= rows_eff) || (col_ext >= cols_eff);
        rect_bad  = (t_ext == '0) || (l_ext == '0) || (t_ext > b_ext) || (l_ext > r_ext)
                    || (b_ext > rows_eff) || (r_ext > cols_eff);
        code_c    = STAT_OK;
        case (r_req.mode)
            MODE_LOAD: begin
                if (load_full) begin
                    code_c = STAT_FULL;
                end
            end
            MODE_QUERY: begin
                if (!r_complete) begin
                    code_c = STAT_INCOMPLETE;
                end else if (rect_bad) begin
                    code_c = STAT_BAD_RECT;
                end
            end
            default: begin
                code_c = STAT_OK;
            end
        endcase
        o_stat.load_go  = (r_req.mode == MODE_LOAD) && !load_full;
        o_stat.query_go = (r_req.mode == MODE_QUERY) && r_complete && !rect_bad;
        o_stat.out_busy = r_out_valid && i_out_stall;
    end

    // Load arithmetic and table addressing.
    always_comb begin
        cell_ext = {{(SUM_W - CELL_W){r_req.cell_value[CELL_W-1]}}, r_req.cell_value};
        run_nx   = ((r_col == '0) ? '0 : r_run) + cell_ext;
        load_sum = (r_rd_zero ? '0 : r_rdata) + r_run;
        col_nx   = r_col + DIM_W'(1);
        row_nx   = r_row + DIM_W'(1);
        ld_row   = row_ext - CW'(1);

        q_row  = b_ext - CW'(1);
        q_col  = r_ext - CW'(1);
        q_zero = 1'b0;
        case (i_cmd.term)
            TERM_BR: begin
                q_row  = b_ext - CW'(1);
                q_col  = r_ext - CW'(1);
                q_zero = 1'b0;
            end
            TERM_BL: begin
                q_row  = b_ext - CW'(1);
                q_col  = l_ext - CW'(2);
                q_zero = (l_ext == CW'(1));
            end
            TERM_TR: begin
                q_row  = t_ext - CW'(2);
                q_col  = r_ext - CW'(1);
                q_zero = (t_ext == CW'(1));
            end
            default: begin
                q_row  = t_ext - CW'(2);
                q_col  = l_ext - CW'(2);
                q_zero = (t_ext == CW'(1)) || (l_ext == CW'(1));
            end
        endcase

        if (i_cmd.load_commit) begin
            addr = tab_addr(row_ext, col_ext);
        end else if (i_cmd.load_read) begin
            addr = tab_addr(ld_row, col_ext);
        end else begin
            addr = tab_addr(q_row, q_col);
        end
        mem_re    = i_cmd.load_read || i_cmd.rd_en;
        rd_zero_c = i_cmd.load_read ? (r_row == '0) : q_zero;

        rd_term_val = r_rd_zero ? '0 : r_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_commit) begin
            mem[addr] <= load_sum;
        end
        if (mem_re) begin
            r_rdata <= mem[addr];
        end
    end

    // Control and loading state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg  <= CFG_W'(64);
            r_cols_cfg  <= CFG_W'(64);
            r_row       <= '0;
            r_col       <= '0;
            r_run       <= '0;
            r_complete  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr && (i_cfg_index == CFG_GRID_ROWS || i_cfg_index == CFG_GRID_COLS)) begin
                if (i_cfg_index == CFG_GRID_ROWS) begin
                    r_rows_cfg <= i_cfg_data;
                end else begin
                    r_cols_cfg <= i_cfg_data;
                end
                r_row      <= '0;
                r_col      <= '0;
                r_run      <= '0;
                r_complete <= 1'b0;
            end else if (i_cmd.decode && r_req.mode == MODE_RESTART) begin
                r_row      <= '0;
                r_col      <= '0;
                r_run      <= '0;
                r_complete <= 1'b0;
            end else if (i_cmd.load_read) begin
                r_run <= run_nx;
            end else if (i_cmd.load_commit) begin
                if (CW'(col_nx) >= cols_eff) begin
                    r_col <= '0;
                    r_run <= '0;
                    r_row <= row_nx;
                    if (CW'(row_nx) >= rows_eff) begin
                        r_complete <= 1'b1;
                    end
                end else begin
                    r_col <= col_nx;
                end
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, accumulator and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_data;
        end
        if (mem_re) begin
            r_term    <= i_cmd.term;
            r_rd_zero <= rd_zero_c;
        end
        if (i_cmd.decode) begin
            r_code <= code_c;
            r_acc  <= '0;
        end else if (i_cmd.load_commit) begin
            r_acc <= load_sum;
        end else if (i_cmd.accum) begin
            if (r_term == TERM_BR || r_term == TERM_TL) begin
                r_acc <= r_acc + rd_term_val;
            end else begin
                r_acc <= r_acc - rd_term_val;
            end
        end
        if (i_cmd.out_load) begin
            r_out.range_sum <= r_acc;
            r_out.status    <= r_code;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/summed_area_range_sum.sv]
// Top level of the summed-area range-sum block: controller, datapath and ports.
//
// Requests arrive on the input channel (i_in_valid, o_in_stall, i_in_data) and each one
// yields exactly one result on the output channel (o_out_valid, i_out_stall, o_out_data).
// A load request writes the next grid cell in raster order and returns the table entry it
// stored; a query request returns the sum over an inclusive, 1-indexed rectangle; a restart
// request clears the loading counters but keeps the table contents.
// The grid size is set through the configuration channel (i_cfg_valid, o_cfg_ready,
// i_cfg_index, i_cfg_data): index 0 is the row count, index 1 the column count. Every such
// write also restarts loading. The channel is always ready and should be written only while
// the block is idle.
// One request is worked on at a time, with the table in a single-port memory. A load
// passes through decode, one read, one write and the output; a query through decode, four
// reads through one accumulator, a final add and the output; and a rejected, restart or
// unused request through decode and the output. The next request can be taken in the
// cycle after the result is registered.
// Reset returns the grid size to 64 by 64, clears the counters and the output valid flag and
// leaves the table contents undefined. While the receiver stalls, the finished result holds
// in the output register; the next request is still accepted and worked on, and waits to be
// registered until the earlier result has been taken.
module summed_area_range_sum
    import sars_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_req                 i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_rsp                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // The register file takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    sars_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    sars_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
